// ----- rtl/bgts_pkg.sv -----
// shared types and constants for the bmp gray threshold stream unit
package bgts_pkg;

   // dimension field width, low bits of the header width and height words
   localparam int DIM_BITS = 32;

   // header byte positions
   localparam logic [8:0] POS_OFFSET     = 9'd10;
   localparam logic [8:0] POS_WIDTH      = 9'd18;
   localparam logic [8:0] POS_HEIGHT     = 9'd22;
   localparam logic [8:0] POS_HEADER_END = 9'd26;
   localparam logic [8:0] POS_SATURATE   = 9'd256;
   localparam logic [7:0] MIN_OFFSET     = 8'd26;

   // divide by three through a reciprocal, exact for sums up to 765
   localparam logic [19:0] DIV3_RECIP = 20'd683;
   localparam int          DIV3_SHIFT = 11;

   localparam logic [7:0] GRAY_THRESHOLD = 8'd128;
   localparam logic [7:0] BYTE_WHITE     = 8'hFF;
   localparam logic [7:0] BYTE_BLACK     = 8'h00;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // input word
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_in;
   } bgts_req_type;

   // output word
   typedef struct packed {
      logic [7:0] byte_out;
      logic       last_out;
      logic       bad_offset;
   } bgts_rsp_type;

   // what the back end emits for one accepted input word
   typedef enum logic [1:0] {
      CMD_ONE,    // byte_c
      CMD_TWO,    // byte_a then byte_c
      CMD_PIXEL   // three copies of the filtered value of a, b, c
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   byte_a;
      logic [7:0]   byte_b;
      logic [7:0]   byte_c;
      logic         last;
      logic         bad;
   } bgts_cmd_type;

   // back end status seen by the top level
   typedef struct packed {
      logic busy;
      logic emit;
   } bgts_back_status_type;

endpackage

// ----- rtl/bgts_front.sv -----
// front end: header parsing, pixel area tracking and command generation
module bgts_front import bgts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  bgts_req_type req_word,
   output logic         cmd_push,
   output bgts_cmd_type cmd
);

   logic [8:0]          header_position_ff, header_position_in;
   logic [7:0]          pixel_start_ff, pixel_start_in;
   logic [31:0]         image_width_ff, image_width_in;
   logic [31:0]         image_height_ff, image_height_in;
   logic [DIM_BITS-1:0] column_count_ff, column_count_in;
   logic [DIM_BITS-1:0] row_count_ff, row_count_in;
   logic [1:0]          component_index_ff, component_index_in;
   logic [1:0]          padding_left_ff, padding_left_in;
   logic [7:0]          held_blue_ff, held_blue_in;
   logic [7:0]          held_green_ff, held_green_in;
   logic                offset_flagged_ff, offset_flagged_in;

   logic [DIM_BITS-1:0] width_dim, height_dim, column_next;
   logic                width_ok, height_ok, in_pixels;
   logic [7:0]          b;
   logic [8:0]          p;
   logic [1:0]          lane;

   assign b = req_word.byte_in;
   assign p = header_position_ff;

   // effective dimensions, zero or negative means no pixel area
   assign width_dim   = image_width_ff[DIM_BITS-1:0];
   assign height_dim  = image_height_ff[DIM_BITS-1:0];
   assign width_ok    = !width_dim[DIM_BITS-1] && (width_dim != '0);
   assign height_ok   = !height_dim[DIM_BITS-1] && (height_dim != '0);
   assign column_next = column_count_ff + DIM_BITS'(1);

   assign in_pixels = (p >= POS_HEADER_END) && !offset_flagged_ff
                      && (p >= {1'b0, pixel_start_ff}) && width_ok && height_ok
                      && (row_count_ff < height_dim);

   // next state and command
   always_comb begin
      header_position_in = (p < POS_SATURATE) ? p + 9'd1 : p;
      pixel_start_in     = pixel_start_ff;
      image_width_in     = image_width_ff;
      image_height_in    = image_height_ff;
      column_count_in    = column_count_ff;
      row_count_in       = row_count_ff;
      component_index_in = component_index_ff;
      padding_left_in    = padding_left_ff;
      held_blue_in       = held_blue_ff;
      held_green_in      = held_green_ff;
      offset_flagged_in  = offset_flagged_ff;
      lane               = 2'(p - POS_WIDTH);

      // header capture
      if (p == POS_OFFSET) begin
         pixel_start_in    = b;
         offset_flagged_in = (b < MIN_OFFSET);
      end else if (p >= POS_WIDTH && p < POS_HEIGHT) begin
         image_width_in[8*lane +: 8] = b;
      end else if (p >= POS_HEIGHT && p < POS_HEADER_END) begin
         lane = 2'(p - POS_HEIGHT);
         image_height_in[8*lane +: 8] = b;
      end

      cmd.kind   = CMD_ONE;
      cmd.byte_a = held_blue_ff;
      cmd.byte_b = held_green_ff;
      cmd.byte_c = b;
      cmd.last   = req_word.last_in;
      cmd.bad    = offset_flagged_in;
      cmd_push   = accept;

      // pixel area walk
      if (!in_pixels) begin
         cmd.kind = CMD_ONE;
      end else if (padding_left_ff != 2'd0) begin
         cmd.kind        = CMD_ONE;
         padding_left_in = padding_left_ff - 2'd1;
         if (padding_left_ff == 2'd1) begin
            column_count_in = '0;
            row_count_in    = row_count_ff + DIM_BITS'(1);
         end
      end else if (component_index_ff == 2'd0) begin
         held_blue_in       = b;
         component_index_in = 2'd1;
         cmd.kind           = CMD_ONE;
         cmd_push           = accept && req_word.last_in;
      end else if (component_index_ff == 2'd1) begin
         held_green_in      = b;
         component_index_in = 2'd2;
         cmd.kind           = CMD_TWO;
         cmd_push           = accept && req_word.last_in;
      end else begin
         cmd.kind           = CMD_PIXEL;
         component_index_in = 2'd0;
         column_count_in    = column_next;
         if (column_next >= width_dim) begin
            // padding per row equals width mod 4 for three byte pixels
            if (width_dim[1:0] == 2'd0) begin
               column_count_in = '0;
               row_count_in    = row_count_ff + DIM_BITS'(1);
            end else begin
               padding_left_in = width_dim[1:0];
            end
         end
      end

      // end of file clears everything
      if (req_word.last_in) begin
         header_position_in = '0;
         pixel_start_in     = '0;
         image_width_in     = '0;
         image_height_in    = '0;
         column_count_in    = '0;
         row_count_in       = '0;
         component_index_in = '0;
         padding_left_in    = '0;
         held_blue_in       = '0;
         held_green_in      = '0;
         offset_flagged_in  = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_position_ff <= '0;
         pixel_start_ff     <= '0;
         image_width_ff     <= '0;
         image_height_ff    <= '0;
         column_count_ff    <= '0;
         row_count_ff       <= '0;
         component_index_ff <= '0;
         padding_left_ff    <= '0;
         held_blue_ff       <= '0;
         held_green_ff      <= '0;
         offset_flagged_ff  <= 1'b0;
      end else if (accept) begin
         header_position_ff <= header_position_in;
         pixel_start_ff     <= pixel_start_in;
         image_width_ff     <= image_width_in;
         image_height_ff    <= image_height_in;
         column_count_ff    <= column_count_in;
         row_count_ff       <= row_count_in;
         component_index_ff <= component_index_in;
         padding_left_ff    <= padding_left_in;
         held_blue_ff       <= held_blue_in;
         held_green_ff      <= held_green_in;
         offset_flagged_ff  <= offset_flagged_in;
      end
   end

endmodule

// ----- rtl/bgts_queue.sv -----
// small command queue between front and back end
module bgts_queue import bgts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bgts_cmd_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output bgts_cmd_type pop_data
);

   bgts_cmd_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW:0]   rd_ptr_ff, rd_ptr_in;

   // status from pointers with wrap bit
   assign valid = (wr_ptr_ff != rd_ptr_ff);
   assign full  = (wr_ptr_ff[QUEUE_AW] != rd_ptr_ff[QUEUE_AW])
                  && (wr_ptr_ff[QUEUE_AW-1:0] == rd_ptr_ff[QUEUE_AW-1:0]);
   assign pop_data = slot_ff[rd_ptr_ff[QUEUE_AW-1:0]];

   assign wr_ptr_in = wr_ptr_ff + (QUEUE_AW+1)'(1);
   assign rd_ptr_in = rd_ptr_ff + (QUEUE_AW+1)'(1);

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff[QUEUE_AW-1:0]] <= push_data;
      end
   end

endmodule

// ----- rtl/bgts_back.sv -----
// back end: expands commands into output words and filters pixels
module bgts_back import bgts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 grayscale_mode,
   input  logic                 q_valid,
   input  bgts_cmd_type         q_data,
   output logic                 q_pop,
   output bgts_rsp_type         rsp_word,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output bgts_back_status_type status
);

   bgts_cmd_type cmd_ff;
   logic         cmd_valid_ff, cmd_valid_in;
   logic [1:0]   step_ff, step_in;
   bgts_rsp_type out_ff;
   logic         out_valid_ff, out_valid_in;

   logic         out_free, emit, final_step;
   logic [9:0]   pixel_sum;
   logic [19:0]  product;
   logic [7:0]   average, filtered, emit_byte;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = cmd_valid_ff && out_free;

   // gray value: sum of three components over three
   assign pixel_sum = 10'(cmd_ff.byte_a) + 10'(cmd_ff.byte_b) + 10'(cmd_ff.byte_c);
   assign product   = 20'(pixel_sum) * DIV3_RECIP;
   assign average   = 8'(product >> DIV3_SHIFT);
   assign filtered  = grayscale_mode ? average
                    : ((average >= GRAY_THRESHOLD) ? BYTE_WHITE : BYTE_BLACK);

   // byte selection and end of command decode
   always_comb begin
      unique case (cmd_ff.kind)
         CMD_ONE: begin
            final_step = 1'b1;
            emit_byte  = cmd_ff.byte_c;
         end
         CMD_TWO: begin
            final_step = (step_ff == 2'd1);
            emit_byte  = (step_ff == 2'd0) ? cmd_ff.byte_a : cmd_ff.byte_c;
         end
         CMD_PIXEL: begin
            final_step = (step_ff == 2'd2);
            emit_byte  = filtered;
         end
         default: begin
            final_step = 1'b1;
            emit_byte  = cmd_ff.byte_c;
         end
      endcase
   end

   // command sequencing
   always_comb begin
      q_pop        = q_valid && (!cmd_valid_ff || (emit && final_step));
      cmd_valid_in = cmd_valid_ff;
      step_in      = step_ff;
      if (emit) begin
         step_in = step_ff + 2'd1;
      end
      if (emit && final_step) begin
         cmd_valid_in = 1'b0;
      end
      if (q_pop) begin
         cmd_valid_in = 1'b1;
         step_in      = 2'd0;
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_data;
      end
      if (emit) begin
         out_ff.byte_out   <= emit_byte;
         out_ff.last_out   <= cmd_ff.last && final_step;
         out_ff.bad_offset <= cmd_ff.bad;
      end
   end

   assign rsp_word    = out_ff;
   assign rsp_empty   = !out_valid_ff;
   assign status.busy = cmd_valid_ff;
   assign status.emit = emit;

endmodule

// ----- rtl/bmp_gray_threshold_stream_unit.sv -----
// top level of the bmp grayscale and threshold stream filter
//
//   channel  ports                        handshake
//   -------  ---------------------------  ------------------------------
//   input    req_push req_full req_word   taken when req_push and !req_full
//   result   rsp_empty rsp_pop rsp_word   taken when rsp_pop and !rsp_empty
//   config   csr_write_en csr_write_data  written when csr_write_en
//
// One input byte is taken per cycle while the four entry command queue has room.
// The output register gives one word per cycle while rsp_pop takes it; a red byte yields three words,
// balanced by the blue and green bytes that yield none, so one byte per cycle holds.
// The first word for an input byte passes through the queue slot, the command register and the output register.
// Reset is synchronous; no clearing pass is needed after it.
// A stalled result side fills the queue and then raises req_full.
module bmp_gray_threshold_stream_unit import bgts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  bgts_req_type req_word,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output bgts_rsp_type rsp_word,
   input  logic         csr_write_en,
   input  logic         csr_write_data
);

   logic                 grayscale_mode_ff;
   logic                 accept, cmd_push, q_full, q_valid, q_pop;
   bgts_cmd_type         cmd, q_data;
   bgts_back_status_type back_status;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         grayscale_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         grayscale_mode_ff <= csr_write_data;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // front end
   bgts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   // command queue
   bgts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   // back end
   bgts_back u_back (
      .clock          (clock),
      .reset          (reset),
      .grayscale_mode (grayscale_mode_ff),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_word       (rsp_word),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .status         (back_status)
   );

`ifndef SYNTHESIS
   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full && !back_status.busy))
      else $error("block not idle after reset");

   // back end takes a command only when the queue holds one
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command queue popped while empty");

   // a new word never overwrites an unread output word
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      back_status.emit |-> (rsp_empty || rsp_pop))
      else $error("output word overwritten");

   // back end idle with an empty queue leaves no word in flight
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!back_status.busy && !q_valid && !cmd_push && rsp_empty) |=> rsp_empty)
      else $error("word appeared from an idle back end");
`endif

endmodule

// ----- tb/bgts_stream_checker.sv -----
`timescale 1ns / 100ps
// checker that predicts and compares the output words of the bmp gray threshold stream unit
module bgts_stream_checker import bgts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  bgts_req_type req_word,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  bgts_rsp_type rsp_word,
   input  logic         csr_write_en,
   input  logic         csr_write_data,
   output int           error_count,
   output int           pending_words
);

   // predicted copy of the register and the per-file parse state
   logic        gray_mode;
   logic [8:0]  byte_pos;
   logic [7:0]  pixel_offset;
   logic [31:0] width_word;
   logic [31:0] height_word;
   logic [31:0] column_num;
   logic [31:0] row_num;
   logic [1:0]  color_phase;
   logic [1:0]  pad_left;
   logic [7:0]  blue_byte;
   logic [7:0]  green_byte;
   logic        offset_bad;

   // output words still due, oldest first
   bgts_rsp_type due_words[$];

   // a dimension counts only when positive within DIM_BITS bits
   function automatic logic [31:0] positive_dim(input logic [31:0] v);
      logic [DIM_BITS-1:0] low;
      low = v[DIM_BITS-1:0];
      if (low[DIM_BITS-1])
         return '0;
      return 32'(low);
   endfunction

   task automatic clear_file_state();
      byte_pos     = '0;
      pixel_offset = '0;
      width_word   = '0;
      height_word  = '0;
      column_num   = '0;
      row_num      = '0;
      color_phase  = '0;
      pad_left     = '0;
      blue_byte    = '0;
      green_byte   = '0;
      offset_bad   = 1'b0;
   endtask

   // work out the words caused by one input byte
   task automatic filter_byte(input logic [7:0] b, input logic is_last);
      logic [8:0]   pos;
      logic [31:0]  w;
      logic [31:0]  h;
      logic [9:0]   sum;
      logic [7:0]   avg;
      logic [7:0]   val;
      logic [7:0]   outs [0:2];
      logic         in_pixels;
      int           n;
      bgts_rsp_type word;
      pos = byte_pos;
      n = 0;
      if (byte_pos < POS_SATURATE)
         byte_pos = byte_pos + 9'd1;

      // header capture
      if (pos == POS_OFFSET) begin
         pixel_offset = b;
         offset_bad   = (b < MIN_OFFSET);
      end else if (pos >= POS_WIDTH && pos < POS_HEIGHT) begin
         width_word[8 * int'(pos - POS_WIDTH) +: 8] = b;
      end else if (pos >= POS_HEIGHT && pos < POS_HEADER_END) begin
         height_word[8 * int'(pos - POS_HEIGHT) +: 8] = b;
      end

      w = positive_dim(width_word);
      h = positive_dim(height_word);
      in_pixels = pos >= POS_HEADER_END && !offset_bad && pos >= {1'b0, pixel_offset}
                  && w != 0 && h != 0 && row_num < h;

      if (!in_pixels) begin
         outs[n] = b;
         n++;
      end else if (pad_left != 0) begin
         // row padding passes through
         outs[n] = b;
         n++;
         pad_left = pad_left - 2'd1;
         if (pad_left == 0) begin
            column_num = '0;
            row_num    = row_num + 1;
         end
      end else if (color_phase == 2'd0) begin
         blue_byte   = b;
         color_phase = 2'd1;
         if (is_last) begin
            outs[n] = b;
            n++;
         end
      end else if (color_phase == 2'd1) begin
         green_byte  = b;
         color_phase = 2'd2;
         if (is_last) begin
            outs[0] = blue_byte;
            outs[1] = b;
            n = 2;
         end
      end else begin
         // red completes the pixel
         sum = 10'(blue_byte) + 10'(green_byte) + 10'(b);
         avg = 8'(sum / 10'd3);
         if (gray_mode)
            val = avg;
         else
            val = (avg >= GRAY_THRESHOLD) ? BYTE_WHITE : BYTE_BLACK;
         outs[0] = val;
         outs[1] = val;
         outs[2] = val;
         n = 3;
         color_phase = 2'd0;
         column_num  = column_num + 1;
         if (column_num >= w) begin
            // (4 - 3w mod 4) mod 4 reduces to w mod 4
            if (w[1:0] == 2'd0) begin
               column_num = '0;
               row_num    = row_num + 1;
            end else begin
               pad_left = w[1:0];
            end
         end
      end

      for (int k = 0; k < n; k++) begin
         word.byte_out   = outs[k];
         word.last_out   = is_last && (k == n - 1);
         word.bad_offset = offset_bad;
         due_words.push_back(word);
      end
      if (is_last)
         clear_file_state();
   endtask

   // compare one accepted output word with the oldest one due
   task automatic check_word(input bgts_rsp_type got);
      bgts_rsp_type want;
      if (due_words.size() == 0) begin
         error_count++;
         $display("%0t: unexpected word, actual byte %02h last %0b bad %0b", $time,
                  got.byte_out, got.last_out, got.bad_offset);
      end else begin
         want = due_words.pop_front();
         if (got.byte_out !== want.byte_out) begin
            error_count++;
            $display("%0t: byte_out expected %02h actual %02h", $time,
                     want.byte_out, got.byte_out);
         end
         if (got.last_out !== want.last_out) begin
            error_count++;
            $display("%0t: last_out expected %0b actual %0b", $time,
                     want.last_out, got.last_out);
         end
         if (got.bad_offset !== want.bad_offset) begin
            error_count++;
            $display("%0t: bad_offset expected %0b actual %0b", $time,
                     want.bad_offset, got.bad_offset);
         end
      end
   endtask

   initial begin
      error_count   = 0;
      pending_words = 0;
      gray_mode     = 1'b0;
      clear_file_state();
   end

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         gray_mode = 1'b0;
         clear_file_state();
         due_words.delete();
      end else begin
         if (rsp_pop && !rsp_empty)
            check_word(rsp_word);
         if (req_push && !req_full)
            filter_byte(req_word.byte_in, req_word.last_in);
         if (csr_write_en)
            gray_mode = csr_write_data;
      end
      pending_words = due_words.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// stimulus and verdict for the bmp gray threshold stream unit
module testbench;
   import bgts_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 60;

   logic         clock          = 1'b0;
   logic         reset          = 1'b1;
   logic         req_push       = 1'b0;
   logic         req_full;
   bgts_req_type req_word       = '0;
   logic         rsp_empty;
   logic         rsp_pop        = 1'b0;
   bgts_rsp_type rsp_word;
   logic         csr_write_en   = 1'b0;
   logic         csr_write_data = 1'b0;

   int  error_count;
   int  pending_words;
   int  cycle_count    = 0;
   int  send_idle_pct  = 0;
   int  recv_idle_pct  = 0;
   bit  hold_off_req   = 1'b0;
   bit  hold_started   = 1'b0;
   int  hold_left      = 0;

   // pixel bytes to use before random fill
   logic [7:0] preset_body[$];

   bmp_gray_threshold_stream_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_word       (req_word),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   bgts_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_word       (req_word),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .error_count    (error_count),
      .pending_words  (pending_words)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_off_req && !hold_started) begin
         hold_started = 1'b1;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // bytes per pixel row including padding
   function automatic int row_bytes(input int w);
      return 3 * w + (w % 4);
   endfunction

   // a dimension for malformed files
   function automatic logic [31:0] noise_dim();
      case ($urandom_range(3))
         0: return $urandom;
         1: return '0;
         2: return 32'd0 - $urandom_range(1, 4);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   // offer one word; called and returns at a falling edge
   task automatic send_word(input logic [7:0] b, input logic is_last);
      bgts_req_type word;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      word.byte_in  = b;
      word.last_in  = is_last;
      req_push <= 1'b1;
      req_word <= word;
      do
         @(posedge clock);
      while (req_full);
      @(negedge clock);
   endtask

   // stop offering and wait until every word due has come out
   task automatic wait_idle();
      req_push <= 1'b0;
      wait (pending_words == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input logic mode);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= mode;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // build one file: 26 byte header, gap up to the offset, then the body
   task automatic send_file(input logic [7:0] offset, input logic [31:0] w,
                            input logic [31:0] h, input int body_len, input int cut_len);
      logic [7:0] bytes[$];
      int         i;
      for (i = 0; i < 26; i++)
         bytes.push_back(8'($urandom));
      bytes[10] = offset;
      for (i = 0; i < 4; i++) begin
         bytes[18 + i] = w[8 * i +: 8];
         bytes[22 + i] = h[8 * i +: 8];
      end
      while (bytes.size() < int'(offset))
         bytes.push_back(8'($urandom));
      for (i = 0; i < body_len; i++) begin
         if (preset_body.size() > 0)
            bytes.push_back(preset_body.pop_front());
         else
            bytes.push_back(8'($urandom));
      end
      if (cut_len > 0)
         while (bytes.size() > cut_len)
            bytes.delete(bytes.size() - 1);
      for (i = 0; i < bytes.size(); i++)
         send_word(bytes[i], i == bytes.size() - 1);
   endtask

   // a small well-formed image, or a malformed header or cut file
   task automatic random_file(input logic malformed);
      int w;
      int h;
      int body;
      int cut;
      if (!malformed) begin
         w    = $urandom_range(1, 4);
         h    = $urandom_range(1, 2);
         body = h * row_bytes(w) + $urandom_range(0, 2);
         cut  = ($urandom_range(9) == 0) ? $urandom_range(27, 26 + body) : 0;
         send_file(8'($urandom_range(26, 32)), w, h, body, cut);
      end else begin
         cut = ($urandom_range(3) == 0) ? $urandom_range(1, 30) : 0;
         send_file(8'($urandom_range(0, 40)), noise_dim(), noise_dim(),
                   $urandom_range(0, 12), cut);
      end
   endtask

   // boundary pixels: full white, average 128, average 127, pure red
   task automatic boundary_file();
      preset_body = '{8'hFF, 8'hFF, 8'hFF, 8'd127, 8'd128, 8'd129, 8'hFF, 8'h00,
                      8'd127, 8'd127, 8'd128, 8'h00, 8'h00, 8'hFF, 8'h11, 8'h22};
      send_file(8'd28, 32'd2, 32'd2, 16, 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // receiver idles more than sender: directed files, then a random image
      send_idle_pct = 36;
      recv_idle_pct = 52;
      set_mode(1'b0);
      send_file(8'd30, 32'd1, 32'd1, 0, 12);                 // ends inside header
      boundary_file();
      set_mode(1'b1);
      random_file(1'b0);

      // sender idles more than receiver: malformed header or cut file
      set_mode(1'b0);
      send_idle_pct = 52;
      recv_idle_pct = 36;
      random_file(1'b1);

      // no idling, with one long result hold-off to fill the block
      set_mode(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req  = 1'b1;
      send_file(8'd26, 32'd2, 32'd1, row_bytes(2), 0);

      wait_idle();
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/bgts_pkg.sv
rtl/bgts_front.sv
rtl/bgts_queue.sv
rtl/bgts_back.sv
rtl/bmp_gray_threshold_stream_unit.sv
tb/bgts_stream_checker.sv
tb/testbench.sv
